@@ src/spq_pkg.sv @@
// shared types and constants for the sorted priority queue
package spq_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int VALUE_WIDTH_DEFAULT = 16;
   localparam int FIELD_WIDTH         = 16;
   localparam int OCC_WIDTH           = 5;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef struct packed {
      logic                   cmd;
      logic [FIELD_WIDTH-1:0] value;
   } spq_req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] popped_value;
      logic                   popped_valid;
      logic                   full_error;
      logic                   empty_error;
      logic [OCC_WIDTH-1:0]   occupancy;
   } spq_rsp_type;

   typedef struct packed {
      logic                   push;
      logic                   pop;
      logic [FIELD_WIDTH-1:0] value;
   } spq_op_type;

   typedef struct packed {
      logic valid;
      logic keep;
   } spq_link_type;

endpackage

@@ src/spq_cell.sv @@
// one storage cell of the queue, descending order from cell zero
module spq_cell #(
   parameter int WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spq_pkg::spq_op_type  op,
   input  spq_pkg::spq_link_type left_link,
   input  logic [WIDTH-1:0]     left_value,
   input  spq_pkg::spq_link_type right_link,
   input  logic [WIDTH-1:0]     right_value,
   output spq_pkg::spq_link_type link,
   output logic [WIDTH-1:0]     value
);
   import spq_pkg::*;

   logic [WIDTH-1:0] value_ff, value_in;
   logic             valid_ff, valid_in;
   logic [WIDTH-1:0] op_value;
   logic             keep;

   assign op_value = op.value[WIDTH-1:0];
   assign keep     = valid_ff && (value_ff > op_value);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (op.push) begin
         valid_in = valid_ff | left_link.valid;
         if (!keep) begin
            value_in = left_link.keep ? op_value : left_value;
         end
      end else if (op.pop) begin
         value_in = right_value;
         valid_in = right_link.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign link.valid = valid_ff;
   assign link.keep  = keep;
   assign value      = value_ff;

endmodule

@@ src/sorted_priority_queue.sv @@
// top level of the sorted priority queue
//
// a word is taken on req_word at a rising edge with start high and busy low;
// cmd push inserts value, cmd pop removes and returns the greatest entry.
// equal values leave in reverse arrival order.
// every accepted word gives one word on rsp_word, shown for exactly one
// cycle with rsp_strobe high, in the cycle after acceptance.
// the store is a row of DEPTH cells with the greatest entry in cell zero;
// every cell updates from its neighbors in the same cycle, so a word can be
// accepted every cycle while busy is low.
// a push when full raises full_error, a pop when empty raises empty_error;
// neither changes the store. occupancy is the count after the operation.
// busy is high only while reset is held and for the cycle after it.
// reset empties the queue at once; no clearing pass is needed.
// the receiver cannot stall: rsp_word must be taken in its strobe cycle.
module sorted_priority_queue #(
   parameter int DEPTH       = spq_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  spq_pkg::spq_req_type req_word,
   output logic                 rsp_strobe,
   output spq_pkg::spq_rsp_type rsp_word
);
   import spq_pkg::*;

   localparam int STORE_W = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;
   localparam int CNT_W   = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff;
   logic             rsp_strobe_ff;
   spq_rsp_type      rsp_word_ff, rsp_word_in;
   logic             accept, full, empty;
   spq_op_type       op;

   spq_link_type     cell_link  [DEPTH];
   logic [STORE_W-1:0] cell_value [DEPTH];

   assign accept = start && !busy_ff;
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);

   always_comb begin
      op.push  = accept && (req_word.cmd == CMD_PUSH) && !full;
      op.pop   = accept && (req_word.cmd == CMD_POP) && !empty;
      op.value = FIELD_WIDTH'(req_word.value[STORE_W-1:0]);
   end

   always_comb begin
      count_in = count_ff;
      if (op.push) begin
         count_in = count_ff + 1'b1;
      end else if (op.pop) begin
         count_in = count_ff - 1'b1;
      end
      rsp_word_in.popped_value = op.pop ? FIELD_WIDTH'(cell_value[0]) : '0;
      rsp_word_in.popped_valid = op.pop;
      rsp_word_in.full_error   = (req_word.cmd == CMD_PUSH) && full;
      rsp_word_in.empty_error  = (req_word.cmd == CMD_POP) && empty;
      rsp_word_in.occupancy    = OCC_WIDTH'(count_in);
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_link_type       left_link, right_link;
      logic [STORE_W-1:0] left_value, right_value;

      if (i == 0) begin : g_first
         assign left_link  = '{valid: 1'b1, keep: 1'b1};
         assign left_value = '0;
      end else begin : g_inner_left
         assign left_link  = cell_link[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_link  = '{valid: 1'b0, keep: 1'b0};
         assign right_value = '0;
      end else begin : g_inner_right
         assign right_link  = cell_link[i+1];
         assign right_value = cell_value[i+1];
      end

      spq_cell #(
         .WIDTH(STORE_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .left_link  (left_link),
         .left_value (left_value),
         .right_link (right_link),
         .right_value(right_value),
         .link       (cell_link[i]),
         .value      (cell_value[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         busy_ff       <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   a_full_matches_last_cell: assert property (@(posedge clock) disable iff (reset)
      full == cell_link[DEPTH-1].valid)
      else $error("last cell valid disagrees with count");

   a_empty_matches_first_cell: assert property (@(posedge clock) disable iff (reset)
      empty == !cell_link[0].valid)
      else $error("first cell valid disagrees with count");

   a_strobe_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe_ff)
      else $error("accepted word gave no response");

   a_pop_not_error: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_word_ff.popped_valid |->
         !rsp_word_ff.full_error && !rsp_word_ff.empty_error)
      else $error("popped word flagged as error");

   a_empty_error_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_word_ff.empty_error |-> empty)
      else $error("empty error with stored entries");

endmodule
